// ===== rtl/dss_pkg.sv =====
// ----------------------------------------------------------------------------
// dss_pkg
// Shared codes, defaults and types for the split dual stack.
// ----------------------------------------------------------------------------
`default_nettype none

package dss_pkg;

    // default geometry
    localparam int DEF_HALF_DEPTH  = 8;
    localparam int DEF_VALUE_WIDTH = 32;

    // fixed port widths
    localparam int FIELD_W = 32;

    // operation codes
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // stack selection codes
    localparam logic [1:0] STACK_LOWER = 2'd1;
    localparam logic [1:0] STACK_UPPER = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_EMPTY   = 2'd2;
    localparam logic [1:0] ST_NOSTACK = 2'd3;

    // decoded request from the pointer logic
    typedef struct packed {
        logic       wr_en;
        logic       rd_en;
        logic       pop_ok;
        logic [1:0] status;
    } dss_req_t;

endpackage

`default_nettype wire

// ===== rtl/dss_ctrl.sv =====
// ----------------------------------------------------------------------------
// dss_ctrl
// Stack pointers: decodes a request, checks full/empty and forms the address.
// ----------------------------------------------------------------------------
`default_nettype none

module dss_ctrl
    import dss_pkg::*;
#(
    parameter int HALF_DEPTH = DEF_HALF_DEPTH,
    parameter int ADDR_W     = $clog2(2 * HALF_DEPTH)
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire logic              operation,
    input  wire logic [1:0]        stack_number,
    output dss_req_t               req,
    output logic      [ADDR_W-1:0] addr
);

    localparam int CW = $clog2(HALF_DEPTH + 1);
    localparam logic [CW-1:0]     CNT_FULL = CW'(HALF_DEPTH);
    localparam logic [ADDR_W-1:0] TOP_ADDR = ADDR_W'(2 * HALF_DEPTH - 1);

    logic [CW-1:0] lower_count_reg, lower_count_next;
    logic [CW-1:0] upper_count_reg, upper_count_next;
    logic [CW-1:0] cnt;
    logic [CW-1:0] idx;
    logic          sel_lower;
    logic          sel_upper;

    // request decode
    always_comb
    begin
        sel_lower        = (stack_number == STACK_LOWER);
        sel_upper        = (stack_number == STACK_UPPER);
        cnt              = sel_lower ? lower_count_reg : upper_count_reg;
        lower_count_next = lower_count_reg;
        upper_count_next = upper_count_reg;
        req.wr_en        = 1'b0;
        req.rd_en        = 1'b0;
        req.pop_ok       = 1'b0;
        req.status       = ST_OK;
        idx              = cnt;

        if (!sel_lower && !sel_upper)
        begin
            req.status = ST_NOSTACK;
        end
        else if (operation == OP_PUSH)
        begin
            if (cnt >= CNT_FULL)
            begin
                req.status = ST_FULL;
            end
            else
            begin
                req.wr_en = 1'b1;
                if (sel_lower)
                    lower_count_next = lower_count_reg + 1'b1;
                else
                    upper_count_next = upper_count_reg + 1'b1;
            end
        end
        else
        begin
            if (cnt == '0)
            begin
                req.status = ST_EMPTY;
            end
            else
            begin
                idx        = cnt - 1'b1;
                req.rd_en  = 1'b1;
                req.pop_ok = 1'b1;
                if (sel_lower)
                    lower_count_next = lower_count_reg - 1'b1;
                else
                    upper_count_next = upper_count_reg - 1'b1;
            end
        end

        // lower stack grows up from word 0, upper stack down from the top word
        addr = sel_lower ? ADDR_W'(idx) : (TOP_ADDR - ADDR_W'(idx));
    end

    // pointer registers, moved only on an accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lower_count_reg <= '0;
            upper_count_reg <= '0;
        end
        else if (accept)
        begin
            lower_count_reg <= lower_count_next;
            upper_count_reg <= upper_count_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/dss_store.sv =====
// ----------------------------------------------------------------------------
// dss_store
// Shared word store: one write and one registered read per cycle, sharing one address.
// ----------------------------------------------------------------------------
`default_nettype none

module dss_store
    import dss_pkg::*;
#(
    parameter int DEPTH  = 2 * DEF_HALF_DEPTH,
    parameter int ADDR_W = $clog2(DEPTH),
    parameter int DATA_W = DEF_VALUE_WIDTH
)
(
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] addr,
    input  wire logic [DATA_W-1:0] wdata,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[addr] <= wdata;
    end

    // registered read, held until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
            rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/split_dual_stack.sv =====
// ----------------------------------------------------------------------------
// split_dual_stack
// Two LIFO stacks in one shared store, one growing up and one growing down.
// ----------------------------------------------------------------------------
// An accepted item's result enters the output register at the accepting edge.
// Throughput: one item per cycle while no result waits on out_ready; the pointer
// update and the single store access for an item complete at the accepting edge.
// Reset: rst_n clears both stack pointers and the output valid; store words
// stay undefined until pushed, and no clearing pass is needed.
`default_nettype none

module split_dual_stack
    import dss_pkg::*;
#(
    parameter int HALF_DEPTH  = DEF_HALF_DEPTH,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic                      operation,
    input  wire logic [1:0]                stack_number,
    input  wire logic signed [FIELD_W-1:0] push_value,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic [1:0]                     status,
    output logic signed [FIELD_W-1:0]      pop_value
);

    localparam int DEPTH  = 2 * HALF_DEPTH;
    localparam int ADDR_W = $clog2(DEPTH);
    // bits of a pushed value that are kept
    localparam int SW = (VALUE_WIDTH < FIELD_W) ? VALUE_WIDTH : FIELD_W;

    dss_req_t          req;
    logic [ADDR_W-1:0] addr;
    logic [SW-1:0]     rdata;
    logic              accept;
    logic              valid_reg;
    logic [1:0]        status_reg;
    logic              pop_ok_reg;

    assign in_ready = !valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // pointers and request decode
    dss_ctrl #(
        .HALF_DEPTH (HALF_DEPTH),
        .ADDR_W     (ADDR_W)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .operation    (operation),
        .stack_number (stack_number),
        .req          (req),
        .addr         (addr)
    );

    // shared store
    dss_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W),
        .DATA_W (SW)
    ) u_store (
        .clk   (clk),
        .wr_en (accept && req.wr_en),
        .rd_en (accept && req.rd_en),
        .addr  (addr),
        .wdata (push_value[SW-1:0]),
        .rdata (rdata)
    );

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= req.status;
            pop_ok_reg <= req.pop_ok;
        end
    end

    assign out_valid = valid_reg;
    assign status    = status_reg;
    assign pop_value = pop_ok_reg ? $signed(FIELD_W'(rdata)) : '0;

    // a waiting result holds off the input
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !in_ready)
        else $error("input taken while result stalled");

    // only a good pop carries a value
    a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_OK) |-> (pop_value == '0))
        else $error("value on a failed request");

    // a bad stack number gives the matching status
    a_nostack: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && stack_number != STACK_LOWER && stack_number != STACK_UPPER)
        |=> (out_valid && status == ST_NOSTACK))
        else $error("bad stack number not reported");

endmodule

`default_nettype wire
